[rtl/led_pkg.sv]
`timescale 1ns / 1ps

package led_pkg;

  // default sizing
  localparam int WINDOW_WIDTH_DEF = 5;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int THRESHOLD_W      = 16;

  // status from the shared compare unit
  typedef struct packed {
    logic lt;      // a < b
    logic eq;      // a == b
    logic ge_thr;  // a - b >= threshold
  } cmp_flags_t;

  // sequencer steps
  typedef enum logic [3:0] {
    S_IDLE,
    S_LMAX,
    S_LMIN,
    S_SCAN_HI,
    S_SCAN_LO,
    S_CAND,
    S_RMAX,
    S_RMIN,
    S_CMAX_L,
    S_CMAX_R,
    S_CMIN_L,
    S_CMIN_R,
    S_FINISH
  } state_t;

endpackage

[rtl/led_cmp.sv]
`timescale 1ns / 1ps

module led_cmp #(
  parameter int SAMPLE_BITS = led_pkg::SAMPLE_BITS_DEF
) (
  input  logic signed [SAMPLE_BITS-1:0]      a,
  input  logic signed [SAMPLE_BITS-1:0]      b,
  input  logic [led_pkg::THRESHOLD_W-1:0]    threshold,
  output led_pkg::cmp_flags_t                flags
);

  // difference wide enough for any pair of samples and the full threshold
  localparam int DIFF_W = (SAMPLE_BITS + 2 > led_pkg::THRESHOLD_W + 2) ?
                          SAMPLE_BITS + 2 : led_pkg::THRESHOLD_W + 2;

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] thr_ext;

  // exact subtract, no wrap
  assign diff    = DIFF_W'(a) - DIFF_W'(b);
  assign thr_ext = $signed({{(DIFF_W - led_pkg::THRESHOLD_W){1'b0}}, threshold});

  assign flags.lt     = diff[DIFF_W-1];
  assign flags.eq     = (diff == '0);
  assign flags.ge_thr = (diff >= thr_ext);

endmodule

[rtl/local_extrema_detector.sv]
`timescale 1ns / 1ps

// each accepted word steps through the sequencer: left-side trackers, then, once the window is full,
// a scan of the window, candidate update, right-side trackers and confirmation, then the output load
// no new word is taken until the last one is through; during warm-up only the left trackers run
// every step goes through the one compare unit
// a result waiting at the output holds the next word at its last step
// reset: synchronous, clears window, trackers, confirmed values, threshold and handshakes
module local_extrema_detector #(
  parameter int WINDOW_WIDTH = led_pkg::WINDOW_WIDTH_DEF,
  parameter int SAMPLE_BITS  = led_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [led_pkg::THRESHOLD_W-1:0]    cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_BITS-1:0]      sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               window_full,
  output logic                               maxima_found,
  output logic                               minima_found,
  output logic signed [SAMPLE_BITS-1:0]      maxima_value,
  output logic signed [SAMPLE_BITS-1:0]      minima_value
);

  localparam int CENTER     = (WINDOW_WIDTH - 1) / 2;
  localparam int LEFT_START = CENTER + 2;
  localparam int CNT_W      = $clog2(WINDOW_WIDTH + 1);
  localparam int IDX_W      = $clog2(WINDOW_WIDTH);

  led_pkg::state_t state, state_next;

  logic signed [SAMPLE_BITS-1:0] win [WINDOW_WIDTH];
  logic [CNT_W-1:0]              count;
  logic [IDX_W-1:0]              idx;
  logic [led_pkg::THRESHOLD_W-1:0] threshold;

  logic signed [SAMPLE_BITS-1:0] hi, lo;
  logic signed [SAMPLE_BITS-1:0] max_left_floor, max_right_floor;
  logic signed [SAMPLE_BITS-1:0] min_left_ceiling, min_right_ceiling;
  logic signed [SAMPLE_BITS-1:0] max_candidate, min_candidate;
  logic signed [SAMPLE_BITS-1:0] max_confirmed, min_confirmed;
  logic max_pending, min_pending;
  logic max_left_fresh, min_left_fresh;
  logic max_right_fresh, min_right_fresh;
  logic left_ok;
  logic max_found, min_found;

  logic signed [SAMPLE_BITS-1:0] cmp_a, cmp_b;
  led_pkg::cmp_flags_t           flags;

  logic signed [SAMPLE_BITS-1:0] left, right, mid, scan_val;
  logic in_accept, out_take, out_load, left_en, full, is_hi, is_lo;

  assign left     = win[CENTER - 1];
  assign right    = win[CENTER + 1];
  assign mid      = win[CENTER];
  assign scan_val = win[idx];

  assign full     = (count == CNT_W'(WINDOW_WIDTH));
  assign left_en  = (count >= CNT_W'(LEFT_START));
  assign is_hi    = (mid == hi);
  assign is_lo    = (mid == lo);

  assign in_stall  = (state != led_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  // shared compare unit
  led_cmp #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cmp (
    .a         (cmp_a),
    .b         (cmp_b),
    .threshold (threshold),
    .flags     (flags)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= led_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and compare operand selection
  always_comb begin
    state_next = state;
    cmp_a      = '0;
    cmp_b      = '0;
    out_load   = 1'b0;
    case (state)
      led_pkg::S_IDLE: begin
        if (in_accept) begin
          state_next = led_pkg::S_LMAX;
        end
      end
      led_pkg::S_LMAX: begin
        cmp_a      = left;
        cmp_b      = max_left_floor;
        state_next = led_pkg::S_LMIN;
      end
      led_pkg::S_LMIN: begin
        cmp_a      = min_left_ceiling;
        cmp_b      = left;
        state_next = full ? led_pkg::S_SCAN_HI : led_pkg::S_FINISH;
      end
      led_pkg::S_SCAN_HI: begin
        cmp_a      = hi;
        cmp_b      = scan_val;
        state_next = led_pkg::S_SCAN_LO;
      end
      led_pkg::S_SCAN_LO: begin
        cmp_a      = scan_val;
        cmp_b      = lo;
        state_next = (idx == IDX_W'(WINDOW_WIDTH - 1)) ? led_pkg::S_CAND
                                                       : led_pkg::S_SCAN_HI;
      end
      led_pkg::S_CAND: begin
        cmp_a      = mid;
        cmp_b      = is_hi ? max_candidate : min_candidate;
        state_next = led_pkg::S_RMAX;
      end
      led_pkg::S_RMAX: begin
        cmp_a      = right;
        cmp_b      = max_right_floor;
        state_next = led_pkg::S_RMIN;
      end
      led_pkg::S_RMIN: begin
        cmp_a      = min_right_ceiling;
        cmp_b      = right;
        state_next = led_pkg::S_CMAX_L;
      end
      led_pkg::S_CMAX_L: begin
        cmp_a      = max_candidate;
        cmp_b      = max_left_floor;
        state_next = led_pkg::S_CMAX_R;
      end
      led_pkg::S_CMAX_R: begin
        cmp_a      = max_candidate;
        cmp_b      = max_right_floor;
        state_next = led_pkg::S_CMIN_L;
      end
      led_pkg::S_CMIN_L: begin
        cmp_a      = min_left_ceiling;
        cmp_b      = min_candidate;
        state_next = led_pkg::S_CMIN_R;
      end
      led_pkg::S_CMIN_R: begin
        cmp_a      = min_right_ceiling;
        cmp_b      = min_candidate;
        state_next = led_pkg::S_FINISH;
      end
      led_pkg::S_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = led_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = led_pkg::S_IDLE;
      end
    endcase
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  // sample window and saturating count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_WIDTH; i++) begin
        win[i] <= '0;
      end
      count <= '0;
    end else if (in_accept) begin
      for (int i = 0; i < WINDOW_WIDTH - 1; i++) begin
        win[i] <= win[i + 1];
      end
      win[WINDOW_WIDTH - 1] <= sample;
      if (!full) begin
        count <= count + 1'b1;
      end
    end
  end

  // tracker, candidate and confirmation updates
  always_ff @(posedge clk) begin
    if (rst) begin
      idx               <= '0;
      hi                <= '0;
      lo                <= '0;
      max_left_floor    <= '0;
      max_right_floor   <= '0;
      min_left_ceiling  <= '0;
      min_right_ceiling <= '0;
      max_candidate     <= '0;
      min_candidate     <= '0;
      max_confirmed     <= '0;
      min_confirmed     <= '0;
      max_pending       <= 1'b0;
      min_pending       <= 1'b0;
      max_left_fresh    <= 1'b1;
      min_left_fresh    <= 1'b1;
      max_right_fresh   <= 1'b0;
      min_right_fresh   <= 1'b0;
      left_ok           <= 1'b0;
      max_found         <= 1'b0;
      min_found         <= 1'b0;
    end else begin
      case (state)
        led_pkg::S_IDLE: begin
          if (in_accept) begin
            max_found <= 1'b0;
            min_found <= 1'b0;
          end
        end
        led_pkg::S_LMAX: begin
          if (left_en) begin
            if (max_left_fresh) begin
              max_left_floor <= left;
              max_left_fresh <= 1'b0;
            end else if (!max_pending && flags.lt) begin
              max_left_floor <= left;
            end
          end
        end
        led_pkg::S_LMIN: begin
          if (left_en) begin
            if (min_left_fresh) begin
              min_left_ceiling <= left;
              min_left_fresh   <= 1'b0;
            end else if (!min_pending && flags.lt) begin
              min_left_ceiling <= left;
            end
          end
          // seed the window scan
          hi  <= win[0];
          lo  <= win[0];
          idx <= IDX_W'(1);
        end
        led_pkg::S_SCAN_HI: begin
          if (flags.lt) begin
            hi <= scan_val;
          end
        end
        led_pkg::S_SCAN_LO: begin
          if (flags.lt) begin
            lo <= scan_val;
          end
          idx <= idx + 1'b1;
        end
        led_pkg::S_CAND: begin
          if (is_hi) begin
            if (max_pending) begin
              if (!flags.lt && !flags.eq) begin
                max_candidate <= mid;
              end
            end else begin
              max_candidate   <= mid;
              max_pending     <= 1'b1;
              max_right_fresh <= 1'b1;
            end
          end else if (is_lo) begin
            if (min_pending) begin
              if (flags.lt) begin
                min_candidate <= mid;
              end
            end else begin
              min_candidate   <= mid;
              min_pending     <= 1'b1;
              min_right_fresh <= 1'b1;
            end
          end
        end
        led_pkg::S_RMAX: begin
          if (max_right_fresh) begin
            max_right_floor <= right;
            max_right_fresh <= 1'b0;
          end else if (max_pending && flags.lt) begin
            max_right_floor <= right;
          end
        end
        led_pkg::S_RMIN: begin
          if (min_right_fresh) begin
            min_right_ceiling <= right;
            min_right_fresh   <= 1'b0;
          end else if (min_pending && flags.lt) begin
            min_right_ceiling <= right;
          end
        end
        led_pkg::S_CMAX_L: begin
          left_ok <= flags.ge_thr;
        end
        led_pkg::S_CMAX_R: begin
          if (max_pending && left_ok && flags.ge_thr) begin
            max_confirmed    <= max_candidate;
            max_pending      <= 1'b0;
            max_left_fresh   <= 1'b1;
            min_left_ceiling <= max_candidate;
            max_found        <= 1'b1;
          end
        end
        led_pkg::S_CMIN_L: begin
          left_ok <= flags.ge_thr;
        end
        led_pkg::S_CMIN_R: begin
          if (min_pending && left_ok && flags.ge_thr) begin
            min_confirmed  <= min_candidate;
            min_pending    <= 1'b0;
            max_left_floor <= min_candidate;
            min_left_fresh <= 1'b1;
            min_found      <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      window_full  <= full;
      maxima_found <= max_found;
      minima_found <= min_found;
      maxima_value <= max_confirmed;
      minima_value <= min_confirmed;
    end
  end

endmodule
